// File: design/ptc_pkg.sv
// Shared constants, codes and result type for the page translation block.
`default_nettype none
package ptc_pkg;

    localparam int PAGE_TABLE_ENTRIES_DEF = 4096;
    localparam int MAX_FRAMES_DEF         = 64;

    localparam int VA_W     = 32;
    localparam int SHIFT_W  = 5;
    localparam int FCOUNT_W = 7;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;
    localparam int CNT_W    = 63;
    localparam int OFFSET_W = 31;
    localparam int FRAME_OUT_W = 6;
    localparam int STATUS_W = 2;
    localparam int RES_W    = 229;
    localparam int M_TDATA_W = 232;

    localparam logic [CFG_IDX_W-1:0] REG_PAGE_SHIFT  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_COUNT = 1'd1;

    localparam logic [SHIFT_W-1:0]  PAGE_SHIFT_RST  = 5'd12;
    localparam logic [FCOUNT_W-1:0] FRAME_COUNT_RST = 7'd64;

    localparam logic [STATUS_W-1:0] STATUS_HIT   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FAULT = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

    typedef struct packed {
        logic [CNT_W-1:0]       fault_count;
        logic [CNT_W-1:0]       reference_count;
        logic [VA_W-1:0]        physical_address;
        logic [FRAME_OUT_W-1:0] frame_index;
        logic [OFFSET_W-1:0]    page_offset;
        logic [VA_W-1:0]        page_number;
        logic [STATUS_W-1:0]    status;
    } ptc_res_t;

endpackage
`default_nettype wire

// File: design/ptc_ram.sv
// Simple dual-port synchronous RAM with registered read data.
`default_nettype none
module ptc_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule
`default_nettype wire

// File: design/ptc_ctrl.sv
// Translation sequencer: page table lookup, frame fill, clock sweep and eviction.
`default_nettype none
module ptc_ctrl #(
    parameter int PAGE_TABLE_ENTRIES = ptc_pkg::PAGE_TABLE_ENTRIES_DEF,
    parameter int MAX_FRAMES         = ptc_pkg::MAX_FRAMES_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic [ptc_pkg::SHIFT_W-1:0]    page_shift,
    input  wire logic [ptc_pkg::FCOUNT_W-1:0]   frame_count,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [ptc_pkg::VA_W-1:0]       in_va,
    output logic                                res_valid,
    input  wire logic                           res_ready,
    output ptc_pkg::ptc_res_t                   res
);
    import ptc_pkg::*;

    localparam int PW = $clog2(PAGE_TABLE_ENTRIES);
    localparam int FW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int NW = $clog2(MAX_FRAMES + 1);
    localparam int CW = (NW > FCOUNT_W) ? NW : FCOUNT_W;
    localparam logic [CW-1:0] MAXF = CW'(MAX_FRAMES);
    localparam logic [PW-1:0] LAST_ENTRY = PW'(PAGE_TABLE_ENTRIES - 1);
    localparam logic [VA_W-1:0] PTE_LIMIT = VA_W'(PAGE_TABLE_ENTRIES);

    typedef enum logic [2:0] {
        ST_CLEAR, ST_IDLE, ST_LOOKUP, ST_SWEEP_RD, ST_SWEEP_CHK, ST_EVICT, ST_DONE
    } state_t;

    typedef struct packed {
        logic          valid;
        logic [FW-1:0] frame;
    } pt_entry_t;

    typedef struct packed {
        logic [PW-1:0] page;
        logic          refbit;
    } fr_entry_t;

    state_t            state_reg, state_next;
    logic [PW-1:0]     clr_reg, clr_next;
    logic [VA_W-1:0]   page_reg, page_next;
    logic [OFFSET_W-1:0] offset_reg, offset_next;
    logic [CNT_W-1:0]  refs_reg, refs_next;
    logic [CNT_W-1:0]  faults_reg, faults_next;
    logic [FW-1:0]     hand_reg, hand_next;
    logic [NW-1:0]     fill_reg, fill_next;
    logic [FW-1:0]     cur_reg, cur_next;
    logic [FW-1:0]     frame_reg, frame_next;
    logic [STATUS_W-1:0] status_reg, status_next;

    logic              pt_we;
    logic [PW-1:0]     pt_waddr, pt_raddr;
    pt_entry_t         pt_wdata, pt_rdata;
    logic              fr_we;
    logic [FW-1:0]     fr_waddr, fr_raddr;
    fr_entry_t         fr_wdata, fr_rdata;

    logic [CW-1:0]     n_frames;
    logic [CW-1:0]     hand_ext, cur_inc, fill_ext;
    logic [FW-1:0]     hand_eff, cur_wrap;
    logic [VA_W-1:0]   va_page;
    logic [VA_W-1:0]   va_mask;
    logic              fin;
    logic [STATUS_W-1:0] fin_status;
    logic [FW-1:0]     fin_frame;

    ptc_ram #(.WIDTH(1 + FW), .DEPTH(PAGE_TABLE_ENTRIES), .ADDR_W(PW)) u_page_ram (
        .aclk  (aclk),
        .we    (pt_we),
        .waddr (pt_waddr),
        .wdata (pt_wdata),
        .raddr (pt_raddr),
        .rdata (pt_rdata)
    );

    ptc_ram #(.WIDTH(PW + 1), .DEPTH(MAX_FRAMES), .ADDR_W(FW)) u_frame_ram (
        .aclk  (aclk),
        .we    (fr_we),
        .waddr (fr_waddr),
        .wdata (fr_wdata),
        .raddr (fr_raddr),
        .rdata (fr_rdata)
    );

    always_comb begin
        if (frame_count == '0) begin
            n_frames = CW'(1);
        end else if (CW'(frame_count) > MAXF) begin
            n_frames = MAXF;
        end else begin
            n_frames = CW'(frame_count);
        end
        hand_ext = CW'(hand_reg);
        hand_eff = (hand_ext < n_frames) ? hand_reg : '0;
        cur_inc  = CW'(cur_reg) + CW'(1);
        cur_wrap = (cur_inc < n_frames) ? FW'(cur_inc) : '0;
        fill_ext = CW'(fill_reg);
        va_page  = in_va >> page_shift;
        va_mask  = (VA_W'(1) << page_shift) - VA_W'(1);
    end

    assign in_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        page_next   = page_reg;
        offset_next = offset_reg;
        refs_next   = refs_reg;
        faults_next = faults_reg;
        hand_next   = hand_reg;
        fill_next   = fill_reg;
        cur_next    = cur_reg;
        frame_next  = frame_reg;
        status_next = status_reg;
        pt_we       = 1'b0;
        pt_waddr    = page_reg[PW-1:0];
        pt_wdata    = '0;
        pt_raddr    = page_reg[PW-1:0];
        fr_we       = 1'b0;
        fr_waddr    = cur_reg;
        fr_wdata    = '0;
        fr_raddr    = cur_reg;
        fin         = 1'b0;
        fin_status  = status_reg;
        fin_frame   = frame_reg;

        case (state_reg)
            ST_CLEAR: begin
                pt_we    = 1'b1;
                pt_waddr = clr_reg;
                clr_next = clr_reg + PW'(1);
                if (clr_reg == LAST_ENTRY) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                pt_raddr = va_page[PW-1:0];
                if (in_valid) begin
                    page_next   = va_page;
                    offset_next = OFFSET_W'(in_va & va_mask);
                    refs_next   = refs_reg + CNT_W'(1);
                    state_next  = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                if (page_reg >= PTE_LIMIT) begin
                    fin        = 1'b1;
                    fin_status = STATUS_RANGE;
                    fin_frame  = '0;
                end else if (pt_rdata.valid) begin
                    fr_we           = 1'b1;
                    fr_waddr        = pt_rdata.frame;
                    fr_wdata.page   = page_reg[PW-1:0];
                    fr_wdata.refbit = 1'b1;
                    fin        = 1'b1;
                    fin_status = STATUS_HIT;
                    fin_frame  = pt_rdata.frame;
                end else begin
                    faults_next = faults_reg + CNT_W'(1);
                    if (fill_ext < n_frames) begin
                        pt_we           = 1'b1;
                        pt_wdata.valid  = 1'b1;
                        pt_wdata.frame  = FW'(fill_reg);
                        fr_we           = 1'b1;
                        fr_waddr        = FW'(fill_reg);
                        fr_wdata.page   = page_reg[PW-1:0];
                        fr_wdata.refbit = 1'b1;
                        fill_next  = fill_reg + NW'(1);
                        fin        = 1'b1;
                        fin_status = STATUS_FAULT;
                        fin_frame  = FW'(fill_reg);
                    end else begin
                        state_next = ST_SWEEP_RD;
                    end
                end
            end
            ST_SWEEP_RD: begin
                fr_raddr   = hand_eff;
                cur_next   = hand_eff;
                state_next = ST_SWEEP_CHK;
            end
            ST_SWEEP_CHK: begin
                hand_next = cur_wrap;
                if (fr_rdata.refbit) begin
                    fr_we           = 1'b1;
                    fr_wdata.page   = fr_rdata.page;
                    fr_wdata.refbit = 1'b0;
                    state_next      = ST_SWEEP_RD;
                end else begin
                    pt_we      = 1'b1;
                    pt_waddr   = fr_rdata.page;
                    state_next = ST_EVICT;
                end
            end
            ST_EVICT: begin
                pt_we           = 1'b1;
                pt_wdata.valid  = 1'b1;
                pt_wdata.frame  = cur_reg;
                fr_we           = 1'b1;
                fr_wdata.page   = page_reg[PW-1:0];
                fr_wdata.refbit = 1'b1;
                fin        = 1'b1;
                fin_status = STATUS_FAULT;
                fin_frame  = cur_reg;
            end
            ST_DONE: begin
                fin = 1'b1;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (fin) begin
            status_next = fin_status;
            frame_next  = fin_frame;
            state_next  = res_ready ? ST_IDLE : ST_DONE;
        end
    end

    always_comb begin
        res.status           = fin_status;
        res.page_number      = page_reg;
        res.page_offset      = offset_reg;
        res.frame_index      = FRAME_OUT_W'(fin_frame);
        res.reference_count  = refs_reg;
        res.fault_count      = faults_next;
        if (fin_status == STATUS_RANGE) begin
            res.physical_address = '0;
        end else begin
            res.physical_address = (VA_W'(fin_frame) << page_shift) | VA_W'(offset_reg);
        end
    end

    assign res_valid = fin;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_CLEAR;
            clr_reg    <= '0;
            refs_reg   <= '0;
            faults_reg <= '0;
            hand_reg   <= '0;
            fill_reg   <= '0;
        end else begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            refs_reg   <= refs_next;
            faults_reg <= faults_next;
            hand_reg   <= hand_next;
            fill_reg   <= fill_next;
        end
        page_reg   <= page_next;
        offset_reg <= offset_next;
        cur_reg    <= cur_next;
        frame_reg  <= frame_next;
        status_reg <= status_next;
    end

endmodule
`default_nettype wire

// File: design/page_translate_clock_replace_unit.sv
// Page translation with clock replacement: config registers, sequencer and output register.
// Hit, out-of-range and fault into an empty frame: result via the lookup state and output register;
// no new address is taken until it is handed on. Fault with replacement: the clock hand visits
// frames in turn, one frame read and write-back of the frame table per visit.
// Reset: synchronous, active low; the page table is then swept clear, one entry per cycle, with
// s_tready low. Config writes are taken throughout.
`default_nettype none
module page_translate_clock_replace_unit #(
    parameter int PAGE_TABLE_ENTRIES = ptc_pkg::PAGE_TABLE_ENTRIES_DEF,
    parameter int MAX_FRAMES         = ptc_pkg::MAX_FRAMES_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_wr_en,
    input  wire logic [ptc_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  wire logic [ptc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [ptc_pkg::VA_W-1:0]         s_tdata,   // virtual_address
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // status, page_number, page_offset, frame_index, physical_address,
    // reference_count, fault_count, zero pad
    output logic      [ptc_pkg::M_TDATA_W-1:0]    m_tdata
);
    import ptc_pkg::*;

    logic [SHIFT_W-1:0]  page_shift_reg;
    logic [FCOUNT_W-1:0] frame_count_reg;
    logic                m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic                res_valid;
    logic                res_ready;
    ptc_res_t            res;

    assign res_ready = !m_tvalid_reg || m_tready;

    ptc_ctrl #(
        .PAGE_TABLE_ENTRIES (PAGE_TABLE_ENTRIES),
        .MAX_FRAMES         (MAX_FRAMES)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .page_shift  (page_shift_reg),
        .frame_count (frame_count_reg),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_va       (s_tdata),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            page_shift_reg  <= PAGE_SHIFT_RST;
            frame_count_reg <= FRAME_COUNT_RST;
            m_tvalid_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en && cfg_addr == REG_PAGE_SHIFT) begin
                page_shift_reg <= cfg_wdata[SHIFT_W-1:0];
            end
            if (cfg_wr_en && cfg_addr == REG_FRAME_COUNT) begin
                frame_count_reg <= cfg_wdata[FCOUNT_W-1:0];
            end
            if (res_ready) begin
                m_tvalid_reg <= res_valid;
            end
        end
        if (res_ready && res_valid) begin
            m_tdata_reg <= M_TDATA_W'(RES_W'(res));
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
`default_nettype wire

// File: verif/testbench.sv
// Testbench for the page translation unit: directed and random traffic against a clock-replacement scoreboard.
`timescale 1ns / 100ps

import ptc_pkg::*;

class translation_board;
    bit                  pt_valid [PAGE_TABLE_ENTRIES_DEF];
    bit [5:0]            pt_frame [PAGE_TABLE_ENTRIES_DEF];
    bit                  fr_used [MAX_FRAMES_DEF];
    bit [11:0]           fr_page [MAX_FRAMES_DEF];
    bit                  fr_ref [MAX_FRAMES_DEF];
    int                  hand;
    bit [CNT_W-1:0]      refs_total;
    bit [CNT_W-1:0]      faults_total;
    bit [SHIFT_W-1:0]    shift = PAGE_SHIFT_RST;
    bit [FCOUNT_W-1:0]   frame_limit = FRAME_COUNT_RST;
    ptc_res_t            pending_translations [$];
    int                  mismatches;

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        if (idx == REG_PAGE_SHIFT) begin
            shift = value[SHIFT_W-1:0];
        end else begin
            frame_limit = value[FCOUNT_W-1:0];
        end
    endfunction

    function int frames_active();
        if (frame_limit == 0) return 1;
        if (frame_limit > MAX_FRAMES_DEF) return MAX_FRAMES_DEF;
        return frame_limit;
    endfunction

    function int claim_frame(int page);
        int n;
        int f;
        bit found;
        bit placed;
        n = frames_active();
        f = 0;
        found = 0;
        faults_total = faults_total + 1'b1;
        for (int i = 0; i < n && !found; i++) begin
            if (!fr_used[i]) begin
                f = i;
                found = 1;
            end
        end
        if (!found) begin
            placed = 0;
            while (!placed) begin
                if (hand >= n) hand = 0;
                f = hand;
                hand = (hand + 1 < n) ? hand + 1 : 0;
                if (fr_ref[f]) begin
                    fr_ref[f] = 0;
                end else begin
                    placed = 1;
                end
            end
            if (fr_used[f]) begin
                pt_valid[fr_page[f]] = 0;
                pt_frame[fr_page[f]] = 0;
            end
        end
        pt_valid[page] = 1;
        pt_frame[page] = f[5:0];
        fr_used[f] = 1;
        fr_page[f] = page[11:0];
        fr_ref[f] = 1;
        return f;
    endfunction

    function void note_address(logic [VA_W-1:0] va);
        longint unsigned addr;
        longint unsigned page;
        longint unsigned offset;
        longint unsigned phys;
        int frame;
        ptc_res_t want;
        addr = va;
        page = addr >> shift;
        offset = addr & ((64'd1 << shift) - 1);
        refs_total = refs_total + 1'b1;
        frame = 0;
        phys = 0;
        if (page >= PAGE_TABLE_ENTRIES_DEF) begin
            want.status = STATUS_RANGE;
        end else begin
            if (pt_valid[page]) begin
                frame = pt_frame[page];
                fr_ref[frame] = 1;
                want.status = STATUS_HIT;
            end else begin
                frame = claim_frame(int'(page));
                want.status = STATUS_FAULT;
            end
            phys = ((longint'(frame) << shift) | offset) & 64'hFFFF_FFFF;
        end
        want.page_number = page[31:0];
        want.page_offset = offset[30:0];
        want.frame_index = frame[5:0];
        want.physical_address = phys[31:0];
        want.reference_count = refs_total;
        want.fault_count = faults_total;
        pending_translations.push_back(want);
    endfunction

    function void log_mismatch(string what, ptc_res_t want, ptc_res_t got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%s (expected / actual): status %0d / %0d, page %h / %h, offset %h / %h,",
                     what, want.status, got.status, want.page_number, got.page_number,
                     want.page_offset, got.page_offset);
            $display("    frame %0d / %0d, phys %h / %h, refs %0d / %0d, faults %0d / %0d",
                     want.frame_index, got.frame_index, want.physical_address,
                     got.physical_address, want.reference_count, got.reference_count,
                     want.fault_count, got.fault_count);
        end
    endfunction

    function void check_translation(ptc_res_t got);
        ptc_res_t want;
        if (pending_translations.size() == 0) begin
            want = '0;
            log_mismatch("result item with no translation pending", want, got);
            return;
        end
        want = pending_translations.pop_front();
        if (got !== want) log_mismatch("translation mismatch", want, got);
    endfunction
endclass

module testbench;
    localparam int ITEM_TARGET    = 1100;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_CYCLES    = 400;
    localparam int SETTLE_CYCLES  = 8;
    localparam int END_CYCLES     = 20;
    localparam int DIRECTED_COUNT = 22;

    localparam logic [VA_W-1:0] DIRECTED_ADDRS [DIRECTED_COUNT] = '{
        32'h0000_0000, 32'h0000_0FFF, 32'h00FF_FFFF, 32'h0100_0000,
        32'hFFFF_FFFF, 32'h0000_1000, 32'h0000_0000, 32'h0000_2ABC,
        32'h0000_0000, 32'h0000_0FFF, 32'h0000_1000, 32'h0000_0007,
        32'h0000_0000,
        32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h1234_5678,
        32'h0000_0100, 32'h0000_0200, 32'h0000_0300,
        32'h0000_0300, 32'h0000_0400
    };

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_wr_en;
    logic [CFG_IDX_W-1:0]   cfg_addr;
    logic [CFG_DATA_W-1:0]  cfg_wdata;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [VA_W-1:0]        s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;

    translation_board board = new;
    bit hold_req = 0;
    bit hold_done = 0;
    int sent_total;
    int burst_left;
    int quiet_cycles = 0;
    int beat;
    int stall_mode;

    page_translate_clock_replace_unit uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) board.note_address(s_tdata);
        if (aresetn && m_tvalid && m_tready) begin
            board.check_translation(ptc_res_t'(m_tdata[RES_W-1:0]));
        end
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("page_translate_clock_replace_unit test failed");
                $finish;
            end
        end
    end

    initial begin
        m_tready <= 1'b0;
        beat = 0;
        stall_mode = 0;
        forever begin
            @(posedge aclk);
            if (hold_req && !hold_done) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_done = 1;
            end else begin
                if (beat % 48 == 0) stall_mode = $urandom_range(0, 3);
                case (stall_mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(0, 1));
                    2: m_tready <= (beat % 4 == 0);
                    default: m_tready <= ($urandom_range(0, 7) != 0);
                endcase
                beat++;
            end
        end
    end

    task automatic send_address(input logic [VA_W-1:0] va);
        s_tvalid <= 1'b1;
        s_tdata <= va;
        do @(posedge aclk); while (!s_tready);
        sent_total++;
    endtask

    task automatic offer(input logic [VA_W-1:0] va, input bit allow_gaps);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (allow_gaps && $urandom_range(0, 3) != 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            end
        end
        send_address(va);
        burst_left--;
    endtask

    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (board.pending_translations.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic apply_setting(input int new_shift, input int new_count);
        cfg_wr_en <= 1'b1;
        cfg_addr <= REG_PAGE_SHIFT;
        cfg_wdata <= CFG_DATA_W'(new_shift);
        @(posedge aclk);
        board.set_register(REG_PAGE_SHIFT, CFG_DATA_W'(new_shift));
        cfg_addr <= REG_FRAME_COUNT;
        cfg_wdata <= CFG_DATA_W'(new_count);
        @(posedge aclk);
        board.set_register(REG_FRAME_COUNT, CFG_DATA_W'(new_count));
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [VA_W-1:0] pick_address(int sh, int base, int span, int page_lim);
        longint unsigned page;
        longint unsigned mask;
        longint unsigned va;
        int r;
        mask = (64'd1 << sh) - 1;
        r = $urandom_range(0, 99);
        if (r < 84) begin
            page = (base + $urandom_range(0, span - 1)) % page_lim;
        end else if (r < 92) begin
            return $urandom;
        end else if (sh <= 19 && r < 96) begin
            page = PAGE_TABLE_ENTRIES_DEF + $urandom_range(0, 3);
        end else begin
            page = page_lim - 1;
        end
        va = (page << sh) | ({32'd0, $urandom} & mask);
        return va[31:0];
    endfunction

    initial begin
        int sh;
        int cnt;
        int n_eff;
        int page_lim;
        int span;
        int base;
        int n_items;
        int phase_idx;
        bit allow_gaps;

        aresetn <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        cfg_wr_en <= 1'b0;
        cfg_addr <= REG_PAGE_SHIFT;
        cfg_wdata <= '0;
        sent_total = 0;
        burst_left = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < DIRECTED_COUNT; i++) begin
            case (i)
                0: begin
                    wait_results_drained();
                    apply_setting(12, 2);
                end
                8: begin
                    wait_results_drained();
                    apply_setting(0, 0);
                end
                13: begin
                    wait_results_drained();
                    apply_setting(31, 127);
                end
                17: begin
                    wait_results_drained();
                    apply_setting(4, 64);
                end
                20: begin
                    wait_results_drained();
                    apply_setting(4, 2);
                end
                default: ;
            endcase
            offer(DIRECTED_ADDRS[i], 1'b1);
        end

        phase_idx = 0;
        while (sent_total < ITEM_TARGET) begin
            case ($urandom_range(0, 9))
                0: sh = 0;
                1: sh = 31;
                2, 3, 4: sh = 12;
                default: sh = $urandom_range(0, 31);
            endcase
            case ($urandom_range(0, 9))
                0: cnt = 0;
                1: cnt = 1;
                2: cnt = MAX_FRAMES_DEF;
                3: cnt = 127;
                4, 5, 6: cnt = $urandom_range(1, 8);
                default: cnt = $urandom_range(1, MAX_FRAMES_DEF);
            endcase
            wait_results_drained();
            apply_setting(sh, cnt);
            n_eff = (cnt == 0) ? 1 : (cnt > MAX_FRAMES_DEF ? MAX_FRAMES_DEF : cnt);
            page_lim = (sh >= 20) ? (1 << (32 - sh)) : PAGE_TABLE_ENTRIES_DEF;
            span = n_eff + $urandom_range(0, 6);
            base = $urandom_range(0, page_lim - 1);
            n_items = $urandom_range(60, 140);
            allow_gaps = ($urandom_range(0, 3) != 0);
            if (phase_idx == 2) begin
                hold_req = 1;
                allow_gaps = 0;
            end
            for (int k = 0; k < n_items; k++) begin
                offer(pick_address(sh, base, span, page_lim), allow_gaps);
            end
            phase_idx++;
        end

        wait_results_drained();
        repeat (END_CYCLES) @(posedge aclk);
        if (board.mismatches == 0 && board.pending_translations.size() == 0) begin
            $display("page_translate_clock_replace_unit test passed");
        end else begin
            $display("page_translate_clock_replace_unit test failed");
        end
        $finish;
    end
endmodule

// File: files.f
design/ptc_pkg.sv
design/ptc_ram.sv
design/ptc_ctrl.sv
design/page_translate_clock_replace_unit.sv
verif/testbench.sv
